/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the probe level average reporter.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-style invariant sampled on every clock, off during reset.
`define PLV_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication property sampled on every clock, off during reset.
`define PLV_ASSERT_IMPLY(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* hw/rtl/plv_pkg.sv */
// Package of the probe level average reporter: sizes, register indexes,
// reset values. No dependencies.
`default_nettype none
package plv_pkg;

  localparam int NUM_PROBES    = 7;
  localparam int TABLE_ENTRIES = 7;
  localparam int PCT_W         = 7;
  localparam int RING_DEPTH    = 5;
  localparam int RING_IDX_W    = 3;
  localparam int COUNT_W       = 3;
  localparam int SUM_W         = 9;
  localparam int TIME_W        = 32;
  localparam int TENTHS_W      = 10;
  localparam int TABLE_W       = TABLE_ENTRIES * PCT_W;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = TABLE_W;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 16;

  localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;
  localparam logic [SUM_W-1:0]   SUM_MAX   = 9'd500;
  localparam logic [COUNT_W-1:0] COUNT_FULL = 3'(RING_DEPTH);
  localparam logic [RING_IDX_W-1:0] IDX_LAST = 3'(RING_DEPTH - 1);

  localparam logic [TIME_W-1:0]  READ_IV_RST  = 32'd1000;
  localparam logic [TIME_W-1:0]  AVG_IV_RST   = 32'd5000;
  localparam logic [TIME_W-1:0]  HB_IV_RST    = 32'd60000;
  localparam logic [TABLE_W-1:0] TABLE_RST    = 49'd442917286792975;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READ_IV  = 2'd0,
    CFG_AVG_IV   = 2'd1,
    CFG_HB_IV    = 2'd2,
    CFG_TABLE    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                force_request;
    logic                link_up;
    logic [6:0]          probe_wet;
    logic [TIME_W-1:0]   now_ms;
  } in_item_t;

endpackage
`default_nettype wire

/* hw/rtl/probe_level_average_reporter_top.sv */
// Top level of the probe level average reporter: input register, state
// update and output register. Depends on plv_pkg, plv_level_map, assert_macros.svh.
//
//  channel | dir | fields (lsb first)                                  | accepted when
//  in_     | in  | now_ms[31:0] probe_wet[38:32] link_up[39] force[40]  | in_tvalid & in_tready
//  out_    | out | level_tenths[9:0]                                   | out_tvalid & out_tready
//  cfg_    | in  | cfg_index selects register, cfg_wdata value         | cfg_we
//
// One beat per cycle sustained while out_ is not stalled; a result passes the input and output registers to out_.
// The running ring sum keeps the per-beat update to one add and subtract.
// rst_n is synchronous active low; valids and state return to zero, registers to defaults.
// A stalled output holds the input register; in_tready drops only then.
`default_nettype none
module probe_level_average_reporter_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [plv_pkg::IN_TDATA_W-1:0] in_tdata,  // now_ms, probe_wet, link_up, force_request
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [plv_pkg::OUT_TDATA_W-1:0]    out_tdata, // level_tenths
  input  wire logic                          cfg_we,
  input  wire logic [plv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [plv_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import plv_pkg::*;

  `include "assert_macros.svh"

  // configuration
  logic [TIME_W-1:0]  read_iv_r, avg_iv_r, hb_iv_r;
  logic [TABLE_W-1:0] table_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_iv_r <= READ_IV_RST;
      avg_iv_r  <= AVG_IV_RST;
      hb_iv_r   <= HB_IV_RST;
      table_r   <= TABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_READ_IV: read_iv_r <= cfg_wdata[TIME_W-1:0];
        CFG_AVG_IV:  avg_iv_r  <= cfg_wdata[TIME_W-1:0];
        CFG_HB_IV:   hb_iv_r   <= cfg_wdata[TIME_W-1:0];
        CFG_TABLE:   table_r   <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // input register
  logic     in_valid_r;
  in_item_t in_item_r;
  logic     advance;

  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item_t'(in_tdata[$bits(in_item_t)-1:0]);
    end
  end

  // state
  logic [TIME_W-1:0]     last_read_r, last_sent_r;
  logic [PCT_W-1:0]      ring_r [RING_DEPTH];
  logic [RING_IDX_W-1:0] ring_idx_r;
  logic [COUNT_W-1:0]    count_r;
  logic [SUM_W-1:0]      sum_r;
  logic [TENTHS_W-1:0]   pub_r;
  logic                  pub_valid_r;
  logic                  force_r;

  logic [PCT_W-1:0]      pct;
  logic                  fp, due, take, avg_ok, emit, changed, hb_due;
  logic [TIME_W-1:0]     since_read, since_sent;
  logic [SUM_W-1:0]      sum_nxt;
  logic [COUNT_W-1:0]    count_nxt;
  logic [TENTHS_W-1:0]   avg, diff;
  logic                  force_nxt;

  plv_level_map u_map (
    .probe_wet (in_item_r.probe_wet),
    .pct_table (table_r),
    .percent   (pct)
  );

  always_comb begin
    fp         = force_r || in_item_r.force_request;
    since_read = in_item_r.now_ms - last_read_r;
    since_sent = in_item_r.now_ms - last_sent_r;
    due        = (since_read > read_iv_r) || fp;
    take       = due && in_item_r.link_up;
    sum_nxt    = sum_r - SUM_W'(ring_r[ring_idx_r]) + SUM_W'(pct);
    count_nxt  = (count_r < COUNT_FULL) ? count_r + 3'd1 : count_r;
    avg_ok     = take && (count_nxt == COUNT_FULL) && ((since_sent >= avg_iv_r) || fp);
    avg        = {sum_nxt, 1'b0};
    diff       = (avg > pub_r) ? avg - pub_r : pub_r - avg;
    changed    = diff > 10'd1;
    hb_due     = since_sent > hb_iv_r;
    emit       = avg_ok && (changed || hb_due || !pub_valid_r);
    if (due && (!in_item_r.link_up || avg_ok)) begin
      force_nxt = 1'b0;
    end else begin
      force_nxt = fp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_read_r <= '0;
      last_sent_r <= '0;
      ring_idx_r  <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      pub_r       <= '0;
      pub_valid_r <= 1'b0;
      force_r     <= 1'b0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring_r[k] <= '0;
      end
    end else if (advance) begin
      force_r <= force_nxt;
      if (due) begin
        last_read_r <= in_item_r.now_ms;
      end
      if (take) begin
        ring_r[ring_idx_r] <= pct;
        ring_idx_r <= (ring_idx_r == IDX_LAST) ? '0 : ring_idx_r + 3'd1;
        count_r    <= count_nxt;
        sum_r      <= sum_nxt;
      end
      if (emit) begin
        pub_r       <= avg;
        pub_valid_r <= 1'b1;
        last_sent_r <= in_item_r.now_ms;
      end
    end
  end

  // output register
  logic                out_valid_r;
  logic [TENTHS_W-1:0] out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_level_r <= avg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_level_r);

  `PLV_ASSERT_ALWAYS(a_sum_range, sum_r <= SUM_MAX, "ring sum above full scale")
  `PLV_ASSERT_ALWAYS(a_idx_range, ring_idx_r <= IDX_LAST, "ring index out of range")
  `PLV_ASSERT_ALWAYS(a_count_range, count_r <= COUNT_FULL, "sample count above depth")
  `PLV_ASSERT_IMPLY(a_emit_pub, (advance && emit) |=> (pub_valid_r && out_tvalid), "emit lost")

endmodule
`default_nettype wire

/* hw/rtl/plv_level_map.sv */
// Highest wet probe to percent through the packed table, saturated at 100.
// Depends on plv_pkg.
`default_nettype none
module plv_level_map (
  input  wire logic [6:0]                  probe_wet,
  input  wire logic [plv_pkg::TABLE_W-1:0] pct_table,
  output logic      [plv_pkg::PCT_W-1:0]   percent
);
  import plv_pkg::*;

  logic [PCT_W-1:0] raw;

  always_comb begin
    raw = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (i < NUM_PROBES && probe_wet[i]) begin
        raw = pct_table[i*PCT_W +: PCT_W];
      end
    end
    percent = (raw > PCT_MAX) ? PCT_MAX : raw;
  end

endmodule
`default_nettype wire

/* tb/sv/tb_probe_level_average_reporter_top.sv */
// Self-checking testbench for probe_level_average_reporter_top: directed and random
// ticks are checked against a cycle-free level predictor. Depends on plv_pkg and the RTL.
`timescale 1ns / 1ps
module tb_probe_level_average_reporter_top;
  import plv_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [31:0] MS_MAX = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;    // now_ms, probe_wet, link_up, force_request
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // level_tenths
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_READ_IV;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  probe_level_average_reporter_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow registers and level state
  logic [31:0]        read_iv_ms, avg_iv_ms, hb_iv_ms;
  logic [TABLE_W-1:0] pct_map;
  logic [31:0]        last_read_ms, last_pub_ms;
  logic [PCT_W-1:0]   pct_ring [RING_DEPTH];
  int unsigned        ring_wr, n_samples;
  logic [TENTHS_W-1:0] pub_tenths;
  bit                 pub_valid, force_pend;

  logic [TENTHS_W-1:0] pending_levels [$];
  logic [TENTHS_W-1:0] want_level;
  int unsigned         fails = 0;
  int unsigned         cycles = 0;
  int unsigned         hold_off_req = 0;
  bit                  send_idle_on = 1'b1;
  bit                  recv_idle_on = 1'b1;
  logic [31:0]         clock_ms = '0;
  logic [6:0]          last_wet = '0;

  function automatic logic [PCT_W-1:0] top_probe_percent(input logic [6:0] wet);
    logic [PCT_W-1:0] p;
    for (int i = 6; i >= 0; i--) begin
      if (i < TABLE_ENTRIES && wet[i]) begin
        p = pct_map[PCT_W*i +: PCT_W];
        return (p > PCT_MAX) ? PCT_MAX : p;
      end
    end
    return '0;
  endfunction

  task automatic reset_levels();
    read_iv_ms = READ_IV_RST;
    avg_iv_ms = AVG_IV_RST;
    hb_iv_ms = HB_IV_RST;
    pct_map = TABLE_RST;
    last_read_ms = '0;
    last_pub_ms = '0;
    foreach (pct_ring[k]) pct_ring[k] = '0;
    ring_wr = 0;
    n_samples = 0;
    pub_tenths = '0;
    pub_valid = 1'b0;
    force_pend = 1'b0;
  endtask

  task automatic track_tick(input in_item_t tick);
    logic [31:0] since_read, since_pub;
    logic [SUM_W:0] sum;
    logic [TENTHS_W-1:0] avg, diff;
    bit changed, hb_due;
    if (tick.force_request) force_pend = 1'b1;
    since_read = tick.now_ms - last_read_ms;
    if (!(since_read > read_iv_ms || force_pend)) return;
    last_read_ms = tick.now_ms;
    if (!tick.link_up) begin
      force_pend = 1'b0;
      return;
    end
    pct_ring[ring_wr] = top_probe_percent(tick.probe_wet);
    ring_wr = (ring_wr + 1) % RING_DEPTH;
    if (n_samples < RING_DEPTH) n_samples++;
    since_pub = tick.now_ms - last_pub_ms;
    if (n_samples >= RING_DEPTH && (since_pub >= avg_iv_ms || force_pend)) begin
      sum = '0;
      foreach (pct_ring[k]) sum += pct_ring[k];
      avg = TENTHS_W'(2 * sum);
      diff = (avg > pub_tenths) ? avg - pub_tenths : pub_tenths - avg;
      changed = diff > 1;
      hb_due = since_pub > hb_iv_ms;
      if (changed || hb_due || !pub_valid) begin
        pending_levels.push_back(avg);
        pub_tenths = avg;
        pub_valid = 1'b1;
        last_pub_ms = tick.now_ms;
      end
      force_pend = 1'b0;
    end
  endtask

  // called at a rising edge; leaves in_tvalid high so back-to-back beats need one assignment
  task automatic send_beat(input logic [31:0] now, input logic [6:0] wet,
                           input bit link, input bit force_req);
    in_item_t tick;
    int unsigned gap;
    tick.now_ms = now;
    tick.probe_wet = wet;
    tick.link_up = link;
    tick.force_request = force_req;
    gap = send_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - $bits(in_item_t)){1'b0}}, tick};
    do @(posedge clk); while (!in_tready);
    track_tick(tick);
    clock_ms = now;
    last_wet = wet;
  endtask

  // waits for all expected levels, then lets the pipeline empty
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_levels.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_levels.size() > 0) begin
      $error("%0d level_tenths beats never arrived", pending_levels.size());
      fails++;
      pending_levels.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] rd, input logic [31:0] av,
                            input logic [31:0] hb, input logic [TABLE_W-1:0] map);
    cfg_idx_t idx;
    logic [CFG_DATA_W-1:0] val;
    settle();
    for (int r = 0; r < 4; r++) begin
      idx = cfg_idx_t'(r);
      case (idx)
        CFG_READ_IV: begin val = CFG_DATA_W'(rd); read_iv_ms = rd; end
        CFG_AVG_IV:  begin val = CFG_DATA_W'(av); avg_iv_ms = av; end
        CFG_HB_IV:   begin val = CFG_DATA_W'(hb); hb_iv_ms = hb; end
        default:     begin val = map; pct_map = map; end
      endcase
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [TABLE_W-1:0] random_map();
    return {17'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [6:0] random_wet();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return last_wet;
    if (pick < 6) return 7'((1 << $urandom_range(0, 7)) - 1);
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic run_random_ticks(input int count, input int step_max, input int force_pct);
    logic [31:0] now;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 3) now = $urandom;
      else now = clock_ms + 32'($urandom_range(0, step_max));
      send_beat(now, random_wet(), $urandom_range(0, 99) < 85,
                $urandom_range(0, 99) < force_pct);
    end
  endtask

  // defaults after reset: filling the ring, forced reads, link loss, time wrap
  task automatic test_startup_fill();
    send_beat(32'd0, 7'h00, 1'b1, 1'b0);
    send_beat(32'd1001, 7'h7F, 1'b1, 1'b1);
    send_beat(32'd1002, 7'h01, 1'b1, 1'b0);
    send_beat(32'd1003, 7'h00, 1'b1, 1'b0);
    send_beat(32'd2100, 7'h08, 1'b1, 1'b0);
    send_beat(32'd2101, 7'h40, 1'b1, 1'b1);
    send_beat(MS_MAX, 7'h7F, 1'b0, 1'b1);
    send_beat(32'd5, 7'h7F, 1'b1, 1'b1);
    send_beat(32'd7000, 7'h20, 1'b1, 1'b0);
    send_beat(32'd13000, 7'h20, 1'b1, 1'b0);
    settle();
  endtask

  // entries above 100 saturate; repeated levels are averaged but not republished
  task automatic test_table_saturation();
    set_config(32'd0, 32'd0, MS_MAX,
               {7'd1, 7'd64, 7'd0, 7'd99, 7'd100, 7'd101, 7'd127});
    for (int i = 0; i < 7; i++) send_beat(clock_ms + 32'd3, 7'(1 << i), 1'b1, 1'b0);
    for (int i = 0; i < 5; i++) send_beat(clock_ms + 32'd1, 7'h01, 1'b1, i == 2);
    send_beat(clock_ms + 32'd1, 7'h00, 1'b1, 1'b0);
    settle();
  endtask

  // unchanged level republished once the heartbeat interval is exceeded
  task automatic test_heartbeat();
    set_config(32'd0, 32'd0, 32'd3, TABLE_RST);
    for (int i = 0; i < 6; i++) send_beat(clock_ms + 32'd2, 7'h0F, 1'b1, 1'b0);
    settle();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(32'd0, 32'd0, 32'd20, random_map());
        1: set_config(32'd5, 32'd10, 32'd50, TABLE_RST);
        2: set_config(32'd2, 32'd0, MS_MAX, random_map());
        3: set_config(32'd0, 32'd3, 32'd0, {7{7'd127}});
        4: set_config(MS_MAX, MS_MAX, MS_MAX, random_map());
        default: set_config(32'd0, 32'd0, 32'd0, random_map());
      endcase
      send_idle_on = (ph != 1) && (ph != 3);
      recv_idle_on = (ph != 1) && (ph != 2);
      run_random_ticks(ph == 4 ? 80 : 150, ph == 1 ? 12 : 6, ph == 4 ? 30 : 10);
      settle();
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_backpressure();
    set_config(32'd0, 32'd0, 32'd0, random_map());
    send_idle_on = 1'b0;
    hold_off_req = 400;
    run_random_ticks(80, 3, 20);
    send_idle_on = 1'b1;
    settle();
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_levels.size() == 0) begin
        $error("level_tenths: expected none, got %0d", out_tdata[TENTHS_W-1:0]);
        fails++;
      end else begin
        want_level = pending_levels.pop_front();
        if (out_tdata[TENTHS_W-1:0] !== want_level) begin
          $error("level_tenths: expected %0d, got %0d", want_level,
                 out_tdata[TENTHS_W-1:0]);
          fails++;
        end
      end
    end
  end

  initial begin : receiver
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_req) @(posedge clk);
        hold_off_req = 0;
      end
      stall = recv_idle_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    reset_levels();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_startup_fill();
    test_table_saturation();
    test_heartbeat();
    test_random_phases();
    test_backpressure();
    settle();
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
